### hw/rtl/sacmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sacmc_pkg
// Shared types and constants for the cache miss classifier.
// ----------------------------------------------------------------------------
package sacmc_pkg;

    localparam int SET_BITS  = 10;
    localparam int WAY_BITS  = 3;
    localparam int NUM_WAYS  = 1 << WAY_BITS;
    localparam int NUM_SETS  = 1 << SET_BITS;
    localparam int ROW_BITS  = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int WSEL_BITS = (WAY_BITS > 0) ? WAY_BITS : 1;
    localparam int VROW_W    = NUM_WAYS;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    localparam logic [15:0] LFSR_SEED = 16'd44257;
    localparam logic [13:0] FILL_MAX  = 14'd16383;

    typedef enum logic [1:0] {
        OUT_HIT        = 2'd0,
        OUT_COMPULSORY = 2'd1,
        OUT_CAPACITY   = 2'd2,
        OUT_CONFLICT   = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_READ  = 2'd1,
        ST_WRITE = 2'd2,
        ST_CLEAR = 2'd3
    } t_state;

    localparam logic [1:0] REG_OFFSET = 2'd0;
    localparam logic [1:0] REG_INDEX  = 2'd1;
    localparam logic [1:0] REG_WAYS   = 2'd2;

    typedef struct packed {
        logic clear;
        logic capture;
        logic update;
    } t_cmd;

endpackage
`default_nettype wire

### hw/rtl/sacmc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sacmc_ctrl
// Sequencer: clearing pass after reset, then capture, memory read, then
// classify and write back.
// ----------------------------------------------------------------------------
module sacmc_ctrl
    import sacmc_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_start,
    input  wire  i_clear_done,
    output logic o_busy,
    output t_cmd o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_CLEAR;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_start) n_state = ST_READ;
            ST_READ:  n_state = ST_WRITE;
            ST_WRITE: n_state = ST_IDLE;
            ST_CLEAR: if (i_clear_done) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy        = (r_state != ST_IDLE);
        o_cmd.clear   = (r_state == ST_CLEAR);
        o_cmd.capture = (r_state == ST_IDLE) && i_start;
        o_cmd.update  = (r_state == ST_WRITE);
    end
endmodule
`default_nettype wire

### hw/rtl/sacmc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sacmc_datapath
// Tag/valid store, way compare, replacement LFSR and saturating counters.
// ----------------------------------------------------------------------------
module sacmc_datapath
    import sacmc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cmd        i_cmd,
    input  wire  [31:0] i_address_word,
    input  wire  [4:0]  i_offset_bits,
    input  wire  [3:0]  i_index_bits,
    input  wire  [1:0]  i_way_bits,
    output logic        o_clear_done,
    output logic        o_valid,
    output logic [1:0]  o_outcome,
    output logic [31:0] o_access_count,
    output logic [31:0] o_hit_count,
    output logic [31:0] o_miss_count,
    output logic [31:0] o_compulsory_count,
    output logic [31:0] o_capacity_count,
    output logic [31:0] o_conflict_count
);
    // Tags held one row per set, all ways side by side.
    logic [31:0]     r_tag_mem [NUM_SETS][NUM_WAYS];
    logic [31:0]     r_tag_rd  [NUM_WAYS];
    // Valid bits: one row per set, zeroed row by row after reset.
    logic [VROW_W-1:0] r_vld_mem [NUM_SETS];
    logic [ROW_BITS-1:0] r_clr_row;
    logic [VROW_W-1:0] r_vld_rd;

    logic [31:0]   r_tag;
    logic [ROW_BITS-1:0] r_set;
    logic [3:0]    r_ways_n;  // number of ways in use, 1..8
    logic [WAY_BITS:0] r_wb;
    logic [4:0]    r_ib;
    logic [13:0]   r_fill;
    logic [15:0]   r_lfsr;
    logic [31:0]   r_acc, r_hit, r_miss, r_comp, r_cap, r_conf;

    logic [31:0] w_swap, w_shifted;
    logic [5:0]  w_shift;
    logic [3:0]  w_ib_sat;
    logic [1:0]  w_wb_sat;

    assign w_swap = {i_address_word[7:0], i_address_word[15:8],
                     i_address_word[23:16], i_address_word[31:24]};
    assign w_shift  = {1'b0, i_offset_bits} + {2'b0, i_index_bits};
    assign w_ib_sat = (i_index_bits > 4'(SET_BITS)) ? 4'(SET_BITS) : i_index_bits;
    assign w_wb_sat = (i_way_bits > 2'(WAY_BITS)) ? 2'(WAY_BITS) : i_way_bits;
    assign w_shifted = w_swap >> i_offset_bits;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_tag    <= (w_shift >= 6'd32) ? 32'd0 : (w_swap >> w_shift);
            r_set    <= ROW_BITS'(w_shifted & ((32'd1 << w_ib_sat) - 32'd1));
            r_ways_n <= 4'(4'd1 << w_wb_sat);
            r_wb     <= (WAY_BITS+1)'(w_wb_sat);
            r_ib     <= {1'b0, w_ib_sat};
        end
    end

    // Registered read of the addressed row.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                r_tag_rd[w] <= r_tag_mem[ROW_BITS'(w_shifted &
                               ((32'd1 << w_ib_sat) - 32'd1))][w];
            end
            r_vld_rd <= r_vld_mem[ROW_BITS'(w_shifted & ((32'd1 << w_ib_sat) - 32'd1))];
        end
    end

    // Row counter for the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)         r_clr_row <= '0;
        else if (i_cmd.clear) r_clr_row <= r_clr_row + ROW_BITS'(1);
    end

    assign o_clear_done = (r_clr_row == ROW_BITS'(NUM_SETS - 1));

    // Classification on the read row.
    logic [VROW_W-1:0] w_vld;
    logic [NUM_WAYS-1:0] w_match, w_free;
    logic [WSEL_BITS-1:0] w_way;
    logic        w_write_tag, w_set_valid;
    t_outcome    w_out;
    logic [15:0] w_lfsr_nx;
    logic [17:0] w_blocks;

    assign w_vld = r_vld_rd;
    assign w_lfsr_nx = r_lfsr[0] ? ((r_lfsr >> 1) ^ LFSR_TAPS) : (r_lfsr >> 1);
    assign w_blocks  = 18'(18'd1 << (r_ib + 5'(r_wb)));

    always_comb begin
        logic found;
        found       = 1'b0;
        w_way       = '0;
        w_out       = OUT_HIT;
        w_write_tag = 1'b0;
        w_set_valid = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            w_match[w] = w_vld[w] && (r_tag_rd[w] == r_tag);
            w_free[w]  = !w_vld[w];
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!found && (4'(w) < r_ways_n)) begin
                if (w_match[w]) begin
                    found = 1'b1; w_way = WSEL_BITS'(w); w_out = OUT_HIT;
                end else if (w_free[w]) begin
                    found = 1'b1; w_way = WSEL_BITS'(w); w_out = OUT_COMPULSORY;
                    w_write_tag = 1'b1; w_set_valid = 1'b1;
                end else if (r_ways_n == 4'd1) begin
                    found = 1'b1; w_way = WSEL_BITS'(w); w_out = OUT_CONFLICT;
                    w_write_tag = 1'b1;
                end
            end
        end
        if (!found) begin
            w_way       = WSEL_BITS'(w_lfsr_nx & 16'(r_ways_n - 4'd1));
            w_write_tag = 1'b1;
            if (r_ib == 5'd0 || {4'b0, r_fill} >= w_blocks) w_out = OUT_CAPACITY;
            else                                             w_out = OUT_CONFLICT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && w_write_tag) r_tag_mem[r_set][w_way] <= r_tag;
        if (i_cmd.clear) begin
            r_vld_mem[r_clr_row] <= '0;
        end else if (i_cmd.update && w_set_valid) begin
            r_vld_mem[r_set] <= w_vld | (VROW_W'(1) << w_way);
        end
    end

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    logic w_replace;
    assign w_replace = (w_write_tag && !w_set_valid && r_ways_n != 4'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0; r_lfsr <= LFSR_SEED;
            r_acc <= '0; r_hit <= '0; r_miss <= '0;
            r_comp <= '0; r_cap <= '0; r_conf <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.update;
            if (i_cmd.update) begin
                if (w_set_valid && r_fill < FILL_MAX) r_fill <= r_fill + 14'd1;
                if (w_replace) r_lfsr <= w_lfsr_nx;
                r_acc <= sat_inc(r_acc);
                if (w_out == OUT_HIT) r_hit <= sat_inc(r_hit);
                else                  r_miss <= sat_inc(r_miss);
                if (w_out == OUT_COMPULSORY) r_comp <= sat_inc(r_comp);
                if (w_out == OUT_CAPACITY)   r_cap  <= sat_inc(r_cap);
                if (w_out == OUT_CONFLICT)   r_conf <= sat_inc(r_conf);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) o_outcome <= w_out;
    end

    assign o_access_count     = r_acc;
    assign o_hit_count        = r_hit;
    assign o_miss_count       = r_miss;
    assign o_compulsory_count = r_comp;
    assign o_capacity_count   = r_cap;
    assign o_conflict_count   = r_conf;
endmodule
`default_nettype wire

### hw/rtl/set_assoc_cache_miss_classifier_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_miss_classifier_top
// Classifies each address transaction as hit or compulsory, capacity or
// conflict miss in a set-associative cache model with LFSR replacement.
// ----------------------------------------------------------------------------
// Channel    Direction  Handshake                    Payload
// access     in         i_start while o_busy is low  i_address_word
// result     out        o_done strobe, one cycle     o_outcome and six counts
// config     in         APB write, pready high       offset, index, way bits
//
// An access transaction passes through the controller states in order: the
// accepting edge registers the set's tag and valid row, a wait state follows,
// the write state classifies and writes the row back, and the registered
// strobe follows. A new transaction is accepted at the edge that ends the
// previous strobe, so accesses do not overlap; the three controller states
// set this pace. Reset is synchronous; after it a clearing pass zeroes one
// valid row per cycle, holding o_busy high until all 1024 rows are zero.
// The receiver cannot stall.
// ----------------------------------------------------------------------------
module set_assoc_cache_miss_classifier_top
    import sacmc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    output logic        o_busy,
    input  wire  [31:0] i_address_word,
    output logic        o_done,
    output logic [1:0]  o_outcome,
    output logic [31:0] o_access_count,
    output logic [31:0] o_hit_count,
    output logic [31:0] o_miss_count,
    output logic [31:0] o_compulsory_count,
    output logic [31:0] o_capacity_count,
    output logic [31:0] o_conflict_count,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cmd       w_cmd;
    logic       w_clear_done;
    logic [4:0] r_offset_bits;
    logic [3:0] r_index_bits;
    logic [1:0] r_way_bits;

    assign pready = 1'b1;

    // Register writes complete on the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= 5'd2;
            r_index_bits  <= 4'd6;
            r_way_bits    <= 2'd0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_OFFSET: r_offset_bits <= pwdata[4:0];
                REG_INDEX:  r_index_bits  <= pwdata[3:0];
                REG_WAYS:   r_way_bits    <= pwdata[1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_OFFSET: prdata = {27'd0, r_offset_bits};
            REG_INDEX:  prdata = {28'd0, r_index_bits};
            REG_WAYS:   prdata = {30'd0, r_way_bits};
            default:    prdata = 32'd0;
        endcase
    end

    sacmc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_clear_done (w_clear_done),
        .o_busy       (o_busy),
        .o_cmd        (w_cmd)
    );

    sacmc_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_address_word     (i_address_word),
        .i_offset_bits      (r_offset_bits),
        .i_index_bits       (r_index_bits),
        .i_way_bits         (r_way_bits),
        .o_clear_done       (w_clear_done),
        .o_valid            (o_done),
        .o_outcome          (o_outcome),
        .o_access_count     (o_access_count),
        .o_hit_count        (o_hit_count),
        .o_miss_count       (o_miss_count),
        .o_compulsory_count (o_compulsory_count),
        .o_capacity_count   (o_capacity_count),
        .o_conflict_count   (o_conflict_count)
    );
endmodule
`default_nettype wire
